// ----- rtl/ljpf_pkg.sv -----
// Shared constants, stage payload types and the result clamp for the Lennard-Jones pair unit.
// No dependencies; the top level takes this package by wildcard import.
package ljpf_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int POS_W    = 32;
    localparam int DEPTH_W  = 24;
    localparam int BEAD_W   = 16;
    localparam int CHAIN_W  = 31;
    localparam int RES_W    = 32;
    localparam int SEP_W    = 34;
    localparam int DIST_W   = 32;
    localparam int PROD_W   = 48;
    localparam int EPS_W    = 24;
    localparam int EPS24_W  = 29;
    localparam int SQ_REM_W = 26;
    localparam int SQR_W    = 64;
    localparam int INV2_W   = 38;
    localparam int INV4_W   = 43;
    localparam int INV6_W   = 48;
    localparam int INV12_W  = 63;
    localparam int GAP_W    = 64;
    localparam int MAG_W    = 64;
    localparam int Q_SHIFT  = 32;
    localparam int ENE_SHIFT = 30;
    localparam int ENE_PROD_W = EPS_W + INV12_W;
    localparam int FRC_PROD_W = EPS24_W + GAP_W;

    localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

    // Pair classes decided once the separation and well depth are known.
    localparam logic [1:0] CLS_CALC  = 2'd0;
    localparam logic [1:0] CLS_ZERO  = 2'd1;
    localparam logic [1:0] CLS_NULL  = 2'd2;
    localparam logic [1:0] CLS_CLOSE = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] span;
        logic              dist_neg;
        logic              dist_big;
        logic              dist_zero;
        logic              intra;
    } sep_t;

    typedef struct packed {
        sep_t             sep;
        logic [EPS_W-1:0] eps;
    } sep_eps_t;

    typedef struct packed {
        logic [1:0]        cls;
        logic [DIST_W-1:0] span;
        logic              dist_neg;
        logic [EPS_W-1:0]  eps;
        logic              intra;
    } work_t;

    typedef struct packed {
        work_t             w;
        logic [INV2_W-1:0] ir2;
    } ir2_tag_t;

    typedef struct packed {
        work_t             w;
        logic [INV6_W-1:0] ir6;
    } ir6_tag_t;

    typedef struct packed {
        work_t              w;
        logic               gneg;
        logic [GAP_W-1:0]   g;
        logic [EPS24_W-1:0] eps24;
        logic               eneg;
    } gap_tag_t;

    typedef struct packed {
        work_t            w;
        logic             gneg;
        logic [RES_W-1:0] energy;
        logic             ovf_e;
    } ene_tag_t;

    typedef struct packed {
        ene_tag_t e;
        logic     fsat;
    } frc_tag_t;

    // Saturates a sign and magnitude to signed 32 bits; the top bit flags saturation.
    function automatic logic [RES_W:0] res_clamp(input logic neg, input logic [MAG_W-1:0] mag);
        logic [RES_W:0] r;
        if (neg) begin
            if (mag > MAG_W'(RES_MIN))
                r = {1'b1, RES_MIN};
            else
                r = {1'b0, RES_W'(~mag + MAG_W'(1))};
        end else begin
            if (mag > MAG_W'(RES_MAX))
                r = {1'b1, RES_MAX};
            else
                r = {1'b0, mag[RES_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/ljpf_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
// Carries a valid bit and an opaque tag alongside; no package dependencies.
module ljpf_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int TW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [AW-1:0]    a_in,
    input  logic [BW-1:0]    b_in,
    input  logic [TW-1:0]    tag_in,
    output logic             valid_out,
    output logic [AW+BW-1:0] prod,
    output logic [TW-1:0]    tag_out
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] pp_ll_reg;
    logic [AL+BH-1:0] pp_lh_reg;
    logic [AH+BL-1:0] pp_hl_reg;
    logic [AH+BH-1:0] pp_hh_reg;
    logic [TW-1:0]    tag1_reg;
    logic             v1_reg;
    logic [PW-1:0]    prod_reg;
    logic [PW-1:0]    prod_next;
    logic [TW-1:0]    tag2_reg;
    logic             v2_reg;

    always_comb
    begin
        prod_next = PW'(pp_ll_reg) + (PW'(pp_lh_reg) << BL) + (PW'(pp_hl_reg) << AL)
                  + (PW'(pp_hh_reg) << (AL + BL));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= (AL+BL)'(a_in[AL-1:0]) * (AL+BL)'(b_in[BL-1:0]);
            pp_lh_reg <= (AL+BH)'(a_in[AL-1:0]) * (AL+BH)'(b_in[BW-1:BL]);
            pp_hl_reg <= (AH+BL)'(a_in[AW-1:AL]) * (AH+BL)'(b_in[BL-1:0]);
            pp_hh_reg <= (AH+BH)'(a_in[AW-1:AL]) * (AH+BH)'(b_in[BW-1:BL]);
            tag1_reg  <= tag_in;
            prod_reg  <= prod_next;
            tag2_reg  <= tag1_reg;
        end
    end

    assign valid_out = v2_reg;
    assign prod      = prod_reg;
    assign tag_out   = tag2_reg;

endmodule

// ----- rtl/ljpf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, QW stages deep.
// The starting remainder must be below the divisor; no package dependencies.
module ljpf_div #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] lo_in,
    input  logic [DW-1:0] den_in,
    input  logic [TW-1:0] tag_in,
    output logic          valid_out,
    output logic [QW-1:0] quot,
    output logic [TW-1:0] tag_out
);
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [TW-1:0] tag_reg [QW];
    logic          v_reg   [QW];

    genvar gi;
    for (gi = 0; gi < QW; gi++)
    begin : g_stage
        logic [DW-1:0] rem_cur;
        logic [QW-1:0] lo_cur;
        logic [DW-1:0] den_cur;
        logic [QW-1:0] q_cur;
        logic [TW-1:0] tag_cur;
        logic          v_cur;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (gi == 0)
        begin : g_first
            always_comb
            begin
                rem_cur = rem_in;
                lo_cur  = lo_in;
                den_cur = den_in;
                q_cur   = '0;
                tag_cur = tag_in;
                v_cur   = valid_in;
            end
        end else
        begin : g_next
            always_comb
            begin
                rem_cur = rem_reg[gi-1];
                lo_cur  = lo_reg[gi-1];
                den_cur = den_reg[gi-1];
                q_cur   = q_reg[gi-1];
                tag_cur = tag_reg[gi-1];
                v_cur   = v_reg[gi-1];
            end
        end

        always_comb
        begin
            trial = {rem_cur, lo_cur[QW-1]};
            diff  = trial - {1'b0, den_cur};
            ge    = (trial >= {1'b0, den_cur});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[gi] <= 1'b0;
            else if (en)
                v_reg[gi] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[gi] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                lo_reg[gi]  <= {lo_cur[QW-2:0], 1'b0};
                den_reg[gi] <= den_cur;
                q_reg[gi]   <= {q_cur[QW-2:0], ge};
                tag_reg[gi] <= tag_cur;
            end
        end
    end

    assign valid_out = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

// ----- rtl/lennard_jones_pair_force_unit.sv -----
// Top level of the Lennard-Jones 12-6 pair energy and force pipeline.
// Uses ljpf_pkg, the ljpf_mul partial-product multiplier and the ljpf_div bit-per-stage divider.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid / cfg_ready  cfg_data (chain_length)
//   pair      in         pair_valid / pair_stall positions, depths, beads, wrap_around
//   result    out        result_valid / result_stall energy, force, intra_bead, overflow
//
// One pair enters per clock while no result is held; most of the pipeline depth is the 38-stage
// reciprocal divider, the 32-stage force divider and the 24-stage square root.
// All stages advance together; a held result freezes the whole pipeline and stalls the input.
// Reset clears the valid bits and sets chain_length to zero. cfg_ready is always high.
module lennard_jones_pair_force_unit #(
    parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ljpf_pkg::CHAIN_W-1:0]       cfg_data,
    input  logic                               pair_valid,
    output logic                               pair_stall,
    input  logic signed [ljpf_pkg::POS_W-1:0]  first_position,
    input  logic signed [ljpf_pkg::POS_W-1:0]  second_position,
    input  logic [ljpf_pkg::DEPTH_W-1:0]       first_depth,
    input  logic [ljpf_pkg::DEPTH_W-1:0]       second_depth,
    input  logic [ljpf_pkg::BEAD_W-1:0]        first_bead,
    input  logic [ljpf_pkg::BEAD_W-1:0]        second_bead,
    input  logic                               wrap_around,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [ljpf_pkg::RES_W-1:0]  pair_energy,
    output logic signed [ljpf_pkg::RES_W-1:0]  pair_force,
    output logic                               intra_bead,
    output logic                               overflow
);
    import ljpf_pkg::*;

    localparam logic [SQR_W-1:0] CLOSE_LIM = SQR_W'(1) << (2 * FRAC_BITS - 5);
    localparam logic [SQR_W-1:0] INV_SEED  = SQR_W'(1) << (2 * FRAC_BITS - 6);
    localparam int FRC_SHIFT = RES_W - FRAC_BITS;
    localparam int SQ_N = EPS_W;

    logic en;
    logic [CHAIN_W-1:0] chain_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_length_reg <= '0;
        else if (cfg_valid)
            chain_length_reg <= cfg_data;
    end

    logic res_valid_reg;
    assign en         = !(res_valid_reg && result_stall);
    assign pair_stall = !en;

    // Separation and depth product.
    logic               st1_valid_reg;
    logic [SEP_W-1:0]   st1_sep_reg;
    logic [SEP_W-1:0]   st1_sep_next;
    logic [PROD_W-1:0]  st1_prod_reg;
    logic               st1_intra_reg;

    always_comb
    begin
        st1_sep_next = SEP_W'(second_position) - SEP_W'(first_position)
                     + (wrap_around ? SEP_W'(chain_length_reg) : SEP_W'(0));
    end

    // Magnitude and sign of the separation.
    logic               st2_valid_reg;
    sep_t               st2_sep_reg;
    logic [PROD_W-1:0]  st2_prod_reg;
    logic               st1_neg;
    logic [SEP_W-1:0]   st1_mag;

    always_comb
    begin
        st1_neg = st1_sep_reg[SEP_W-1];
        st1_mag = st1_neg ? (SEP_W'(0) - st1_sep_reg) : st1_sep_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else if (en)
        begin
            st1_valid_reg <= pair_valid;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_sep_reg            <= st1_sep_next;
            st1_prod_reg           <= PROD_W'(first_depth) * PROD_W'(second_depth);
            st1_intra_reg          <= (first_bead == second_bead);
            st2_sep_reg.span       <= st1_mag[DIST_W-1:0];
            st2_sep_reg.dist_neg   <= st1_neg;
            st2_sep_reg.dist_big   <= |st1_mag[SEP_W-1:DIST_W];
            st2_sep_reg.dist_zero  <= (st1_sep_reg == '0);
            st2_sep_reg.intra      <= st1_intra_reg;
            st2_prod_reg           <= st1_prod_reg;
        end
    end

    // Square root of the depth product, one result bit per stage.
    logic [SQ_REM_W-1:0] sq_rem_reg   [SQ_N];
    logic [EPS_W-1:0]    sq_root_reg  [SQ_N];
    logic [PROD_W-1:0]   sq_val_reg   [SQ_N];
    sep_t                sq_tag_reg   [SQ_N];
    logic                sq_valid_reg [SQ_N];

    genvar gi;
    for (gi = 0; gi < SQ_N; gi++)
    begin : g_sqrt
        logic [SQ_REM_W-1:0] rem_cur;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic [EPS_W-1:0]    root_cur;
        logic [PROD_W-1:0]   val_cur;
        sep_t                tag_cur;
        logic                v_cur;
        logic                ge;

        if (gi == 0)
        begin : g_first
            always_comb
            begin
                rem_cur  = '0;
                root_cur = '0;
                val_cur  = st2_prod_reg;
                tag_cur  = st2_sep_reg;
                v_cur    = st2_valid_reg;
            end
        end else
        begin : g_next
            always_comb
            begin
                rem_cur  = sq_rem_reg[gi-1];
                root_cur = sq_root_reg[gi-1];
                val_cur  = sq_val_reg[gi-1];
                tag_cur  = sq_tag_reg[gi-1];
                v_cur    = sq_valid_reg[gi-1];
            end
        end

        // The remainder never exceeds twice the partial root, so its top two bits are free.
        always_comb
        begin
            rem_sh = {rem_cur[SQ_REM_W-3:0], val_cur[PROD_W-1 -: 2]};
            trial  = {root_cur, 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[gi] <= 1'b0;
            else if (en)
                sq_valid_reg[gi] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[gi]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[gi] <= {root_cur[EPS_W-2:0], ge};
                sq_val_reg[gi]  <= {val_cur[PROD_W-3:0], 2'b00};
                sq_tag_reg[gi]  <= tag_cur;
            end
        end
    end

    // Square of the distance.
    sep_eps_t          ms_tag_in;
    sep_eps_t          ms_tag;
    logic [SQR_W-1:0]  ms_prod;
    logic              ms_valid;

    always_comb
    begin
        ms_tag_in.sep = sq_tag_reg[SQ_N-1];
        ms_tag_in.eps = sq_root_reg[SQ_N-1];
    end

    ljpf_mul #(.AW(DIST_W), .BW(DIST_W), .TW($bits(sep_eps_t))) u_mul_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sq_valid_reg[SQ_N-1]),
        .a_in      (ms_tag_in.sep.span),
        .b_in      (ms_tag_in.sep.span),
        .tag_in    (ms_tag_in),
        .valid_out (ms_valid),
        .prod      (ms_prod),
        .tag_out   (ms_tag)
    );

    // Pair classification.
    logic              cl_valid_reg;
    work_t             cl_work_reg;
    logic [SQR_W-1:0]  cl_s_reg;
    logic [1:0]        cl_cls;

    always_comb
    begin
        if (ms_tag.sep.dist_zero)
            cl_cls = CLS_ZERO;
        else if (ms_tag.eps == '0 || ms_tag.sep.dist_big)
            cl_cls = CLS_NULL;
        else if (ms_prod < CLOSE_LIM)
            cl_cls = CLS_CLOSE;
        else
            cl_cls = CLS_CALC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cl_valid_reg <= 1'b0;
        else if (en)
            cl_valid_reg <= ms_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_work_reg.cls      <= cl_cls;
            cl_work_reg.span     <= ms_tag.sep.span;
            cl_work_reg.dist_neg <= ms_tag.sep.dist_neg;
            cl_work_reg.eps      <= ms_tag.eps;
            cl_work_reg.intra    <= ms_tag.sep.intra;
            cl_s_reg             <= ms_prod;
        end
    end

    // Reciprocal of the squared distance with 32 fraction bits.
    logic [INV2_W-1:0] d1_ir2;
    work_t             d1_tag;
    logic              d1_valid;

    ljpf_div #(.DW(SQR_W), .QW(INV2_W), .TW($bits(work_t))) u_div_inv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (cl_valid_reg),
        .rem_in    (INV_SEED),
        .lo_in     ('0),
        .den_in    (cl_s_reg),
        .tag_in    (cl_work_reg),
        .valid_out (d1_valid),
        .quot      (d1_ir2),
        .tag_out   (d1_tag)
    );

    ir2_tag_t                   m4_tag_in;
    ir2_tag_t                   m4_tag;
    logic [2*INV2_W-1:0]        m4_prod;
    logic                       m4_valid;

    always_comb
    begin
        m4_tag_in.w   = d1_tag;
        m4_tag_in.ir2 = d1_ir2;
    end

    ljpf_mul #(.AW(INV2_W), .BW(INV2_W), .TW($bits(ir2_tag_t))) u_mul_ir4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (d1_valid),
        .a_in      (d1_ir2),
        .b_in      (d1_ir2),
        .tag_in    (m4_tag_in),
        .valid_out (m4_valid),
        .prod      (m4_prod),
        .tag_out   (m4_tag)
    );

    work_t                      m6_tag;
    logic [INV4_W+INV2_W-1:0]   m6_prod;
    logic                       m6_valid;

    ljpf_mul #(.AW(INV4_W), .BW(INV2_W), .TW($bits(work_t))) u_mul_ir6 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (m4_valid),
        .a_in      (m4_prod[Q_SHIFT +: INV4_W]),
        .b_in      (m4_tag.ir2),
        .tag_in    (m4_tag.w),
        .valid_out (m6_valid),
        .prod      (m6_prod),
        .tag_out   (m6_tag)
    );

    ir6_tag_t                   m12_tag_in;
    ir6_tag_t                   m12_tag;
    logic [2*INV6_W-1:0]        m12_prod;
    logic                       m12_valid;

    always_comb
    begin
        m12_tag_in.w   = m6_tag;
        m12_tag_in.ir6 = m6_prod[Q_SHIFT +: INV6_W];
    end

    ljpf_mul #(.AW(INV6_W), .BW(INV6_W), .TW($bits(ir6_tag_t))) u_mul_ir12 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (m6_valid),
        .a_in      (m12_tag_in.ir6),
        .b_in      (m12_tag_in.ir6),
        .tag_in    (m12_tag_in),
        .valid_out (m12_valid),
        .prod      (m12_prod),
        .tag_out   (m12_tag)
    );

    // Energy and force differences in sign and magnitude form.
    logic [INV12_W-1:0] df_ir12;
    logic [INV12_W-1:0] df_ir6;
    logic [GAP_W-1:0]   df_two12;
    logic [GAP_W-1:0]   df_ir6g;
    logic               df_eneg;
    logic               df_gneg;
    logic               df_valid_reg;
    gap_tag_t           df_tag_reg;
    logic [INV12_W-1:0] df_de_reg;

    always_comb
    begin
        df_ir12  = m12_prod[Q_SHIFT +: INV12_W];
        df_ir6   = INV12_W'(m12_tag.ir6);
        df_two12 = {df_ir12, 1'b0};
        df_ir6g  = GAP_W'(m12_tag.ir6);
        df_eneg  = (df_ir12 < df_ir6);
        df_gneg  = (df_ir6g < df_two12);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            df_valid_reg <= 1'b0;
        else if (en)
            df_valid_reg <= m12_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            df_tag_reg.w     <= m12_tag.w;
            df_tag_reg.eneg  <= df_eneg;
            df_tag_reg.gneg  <= df_gneg;
            df_tag_reg.g     <= df_gneg ? (df_two12 - df_ir6g) : (df_ir6g - df_two12);
            df_tag_reg.eps24 <= (EPS24_W'(m12_tag.w.eps) << 4) + (EPS24_W'(m12_tag.w.eps) << 3);
            df_de_reg        <= df_eneg ? (df_ir6 - df_ir12) : (df_ir12 - df_ir6);
        end
    end

    gap_tag_t               me_tag;
    logic [ENE_PROD_W-1:0]  me_prod;
    logic                   me_valid;

    ljpf_mul #(.AW(EPS_W), .BW(INV12_W), .TW($bits(gap_tag_t))) u_mul_ene (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (df_valid_reg),
        .a_in      (df_tag_reg.w.eps),
        .b_in      (df_de_reg),
        .tag_in    (df_tag_reg),
        .valid_out (me_valid),
        .prod      (me_prod),
        .tag_out   (me_tag)
    );

    // Energy saturation.
    logic [MAG_W-1:0]   ec_mag;
    logic [RES_W:0]     ec_clamp;
    logic               ec_valid_reg;
    ene_tag_t           ec_tag_reg;
    logic [GAP_W-1:0]   ec_g_reg;
    logic [EPS24_W-1:0] ec_eps24_reg;

    always_comb
    begin
        ec_mag   = MAG_W'(me_prod >> ENE_SHIFT);
        ec_clamp = res_clamp(me_tag.eneg && (ec_mag != '0), ec_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ec_valid_reg <= 1'b0;
        else if (en)
            ec_valid_reg <= me_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ec_tag_reg.w      <= me_tag.w;
            ec_tag_reg.gneg   <= me_tag.gneg;
            ec_tag_reg.energy <= ec_clamp[RES_W-1:0];
            ec_tag_reg.ovf_e  <= ec_clamp[RES_W];
            ec_g_reg          <= me_tag.g;
            ec_eps24_reg      <= me_tag.eps24;
        end
    end

    ene_tag_t               mf_tag;
    logic [FRC_PROD_W-1:0]  mf_prod;
    logic                   mf_valid;

    ljpf_mul #(.AW(EPS24_W), .BW(GAP_W), .TW($bits(ene_tag_t))) u_mul_frc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (ec_valid_reg),
        .a_in      (ec_eps24_reg),
        .b_in      (ec_g_reg),
        .tag_in    (ec_tag_reg),
        .valid_out (mf_valid),
        .prod      (mf_prod),
        .tag_out   (mf_tag)
    );

    // Force numerator; a quotient of 2^32 or more is flagged here and saturates in place of the divider result.
    logic [FRC_PROD_W-1:0]  pr_num;
    logic                   pr_valid_reg;
    frc_tag_t               pr_tag_reg;
    logic [DIST_W-1:0]      pr_rem_reg;
    logic [RES_W-1:0]       pr_lo_reg;

    always_comb
    begin
        pr_num = mf_prod >> FRC_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_valid_reg <= 1'b0;
        else if (en)
            pr_valid_reg <= mf_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_tag_reg.e    <= mf_tag;
            pr_tag_reg.fsat <= (pr_num[FRC_PROD_W-1:Q_SHIFT]
                               >= (FRC_PROD_W-Q_SHIFT)'(mf_tag.w.span));
            pr_rem_reg      <= pr_num[Q_SHIFT +: DIST_W];
            pr_lo_reg       <= pr_num[RES_W-1:0];
        end
    end

    logic [RES_W-1:0] d2_quot;
    frc_tag_t         d2_tag;
    logic             d2_valid;

    ljpf_div #(.DW(DIST_W), .QW(RES_W), .TW($bits(frc_tag_t))) u_div_frc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pr_valid_reg),
        .rem_in    (pr_rem_reg),
        .lo_in     (pr_lo_reg),
        .den_in    (pr_tag_reg.e.w.span),
        .tag_in    (pr_tag_reg),
        .valid_out (d2_valid),
        .quot      (d2_quot),
        .tag_out   (d2_tag)
    );

    // Force saturation, special cases and the output register.
    logic [MAG_W-1:0]  fn_mag;
    logic [RES_W:0]    fn_clamp;
    logic [RES_W-1:0]  fn_energy;
    logic [RES_W-1:0]  fn_force;
    logic              fn_ovf;
    logic [RES_W-1:0]  res_energy_reg;
    logic [RES_W-1:0]  res_force_reg;
    logic              res_intra_reg;
    logic              res_ovf_reg;

    always_comb
    begin
        fn_mag   = d2_tag.fsat ? '1 : MAG_W'(d2_quot);
        fn_clamp = res_clamp((d2_tag.e.gneg != d2_tag.e.w.dist_neg) && (fn_mag != '0), fn_mag);
        case (d2_tag.e.w.cls)
            CLS_ZERO:
            begin
                fn_energy = RES_MAX;
                fn_force  = '0;
                fn_ovf    = 1'b1;
            end
            CLS_NULL:
            begin
                fn_energy = '0;
                fn_force  = '0;
                fn_ovf    = 1'b0;
            end
            CLS_CLOSE:
            begin
                fn_energy = RES_MAX;
                fn_force  = d2_tag.e.w.dist_neg ? RES_MAX : RES_MIN;
                fn_ovf    = 1'b1;
            end
            default:
            begin
                fn_energy = d2_tag.e.energy;
                fn_force  = fn_clamp[RES_W-1:0];
                fn_ovf    = d2_tag.e.ovf_e | fn_clamp[RES_W];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_energy_reg <= fn_energy;
            res_force_reg  <= fn_force;
            res_intra_reg  <= d2_tag.e.w.intra;
            res_ovf_reg    <= fn_ovf;
        end
    end

    assign result_valid = res_valid_reg;
    assign pair_energy  = res_energy_reg;
    assign pair_force   = res_force_reg;
    assign intra_bead   = res_intra_reg;
    assign overflow     = res_ovf_reg;

    a_sat_class: assert property (@(posedge clk) disable iff (!rst_n)
        (en && d2_valid && (d2_tag.e.w.cls == CLS_ZERO || d2_tag.e.w.cls == CLS_CLOSE))
        |=> (result_valid && overflow && pair_energy == RES_MAX))
        else $error("saturating pair class did not give full energy with overflow");

    a_null_class: assert property (@(posedge clk) disable iff (!rst_n)
        (en && d2_valid && d2_tag.e.w.cls == CLS_NULL)
        |=> (result_valid && !overflow && pair_energy == '0 && pair_force == '0))
        else $error("far or zero-depth pair did not give zero results");

    a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> pair_stall)
        else $error("input taken while a result transaction was held");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the Lennard-Jones 12-6 pair force unit: random and directed atom pairs,
// predicted in the bench and checked per transaction. Depends on ljpf_pkg and the RTL top.
`timescale 1ns / 1ps

class pair_force_scoreboard;
    logic [30:0] chain_len;
    logic [31:0] exp_energy[$];
    logic [31:0] exp_force[$];
    bit          exp_intra[$];
    bit          exp_ovf[$];
    int          errors;
    int          checked;

    function new();
        chain_len = '0;
        errors = 0;
        checked = 0;
    endfunction

    static function logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Clamp a sign and magnitude to 32 signed bits.
    static function logic [31:0] clamp(bit neg, logic [127:0] mag, ref bit ovf);
        if (neg)
        begin
            if (mag > 128'h8000_0000)
            begin
                ovf = 1;
                return 32'h8000_0000;
            end
            return 32'(-mag);
        end
        if (mag > 128'h7FFF_FFFF)
        begin
            ovf = 1;
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    function void note_pair(logic signed [31:0] p1, logic signed [31:0] p2,
                            logic [23:0] d1, logic [23:0] d2,
                            logic [15:0] b1, logic [15:0] b2, bit wrap);
        logic signed [63:0] r;
        logic [63:0]        a;
        logic [63:0]        eps;
        logic [127:0]       ir2;
        logic [127:0]       ir4;
        logic [127:0]       ir6;
        logic [127:0]       ir12;
        logic [127:0]       g;
        logic [127:0]       mag;
        logic [31:0]        en;
        logic [31:0]        fo;
        bit                 rneg;
        bit                 ovf;
        bit                 eneg;
        bit                 gneg;
        r = 64'(p2) - 64'(p1) + (wrap ? 64'(chain_len) : 64'd0);
        rneg = r < 0;
        a = rneg ? 64'(-r) : 64'(r);
        eps = isqrt(64'(d1) * 64'(d2));
        ovf = 0;
        en = 0;
        fo = 0;
        if (a == 0)
        begin
            en = 32'h7FFF_FFFF;
            ovf = 1;
        end
        else if (eps == 0 || a >= 64'h1_0000_0000)
        begin
        end
        else if (a * a < (64'd1 << 27))
        begin
            en = 32'h7FFF_FFFF;
            fo = rneg ? 32'h7FFF_FFFF : 32'h8000_0000;
            ovf = 1;
        end
        else
        begin
            ir2 = (128'd1 << 64) / 128'(a * a);
            ir4 = (ir2 * ir2) >> 32;
            ir6 = (ir4 * ir2) >> 32;
            ir12 = (ir6 * ir6) >> 32;
            eneg = ir12 < ir6;
            mag = (128'(eps) * (eneg ? ir6 - ir12 : ir12 - ir6)) >> 30;
            en = clamp(eneg && mag != 0, mag, ovf);
            gneg = ir6 < 2 * ir12;
            g = gneg ? 2 * ir12 - ir6 : ir6 - 2 * ir12;
            mag = ((128'(eps) * 24 * g) >> 16) / 128'(a);
            fo = clamp((gneg != rneg) && mag != 0, mag, ovf);
        end
        exp_energy = {exp_energy, en};
        exp_force = {exp_force, fo};
        exp_intra = {exp_intra, bit'(b1 == b2)};
        exp_ovf = {exp_ovf, ovf};
    endfunction

    function void check_result(logic [31:0] en, logic [31:0] fo, bit intra, bit ovf);
        if (exp_energy.size() == 0)
        begin
            $display("%0t: result with nothing expected", $time);
            errors++;
            return;
        end
        checked++;
        if (exp_energy[0] !== en)
        begin
            $display("%0t: energy expected %h actual %h", $time, exp_energy[0], en);
            errors++;
        end
        if (exp_force[0] !== fo)
        begin
            $display("%0t: force expected %h actual %h", $time, exp_force[0], fo);
            errors++;
        end
        if (exp_intra[0] !== intra)
        begin
            $display("%0t: intra expected %b actual %b", $time, exp_intra[0], intra);
            errors++;
        end
        if (exp_ovf[0] !== ovf)
        begin
            $display("%0t: overflow expected %b actual %b", $time, exp_ovf[0], ovf);
            errors++;
        end
        void'(exp_energy.pop_front());
        void'(exp_force.pop_front());
        void'(exp_intra.pop_front());
        void'(exp_ovf.pop_front());
    endfunction
endclass

module tb_top;
    import ljpf_pkg::*;

    localparam int LATENCY = 113;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CHAIN_W-1:0] cfg_data = '0;
    logic pair_valid = 0;
    logic pair_stall;
    logic signed [POS_W-1:0] first_position = '0;
    logic signed [POS_W-1:0] second_position = '0;
    logic [DEPTH_W-1:0] first_depth = '0;
    logic [DEPTH_W-1:0] second_depth = '0;
    logic [BEAD_W-1:0] first_bead = '0;
    logic [BEAD_W-1:0] second_bead = '0;
    logic wrap_around = 0;
    logic result_valid;
    logic result_stall = 0;
    logic signed [RES_W-1:0] pair_energy;
    logic signed [RES_W-1:0] pair_force;
    logic intra_bead;
    logic overflow;

    int send_idle_pct;
    int recv_idle_pct;
    int cycles = 0;
    int pairs_sent;
    pair_force_scoreboard sb;

    lennard_jones_pair_force_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .pair_valid(pair_valid), .pair_stall(pair_stall),
        .first_position(first_position), .second_position(second_position),
        .first_depth(first_depth), .second_depth(second_depth),
        .first_bead(first_bead), .second_bead(second_bead), .wrap_around(wrap_around),
        .result_valid(result_valid), .result_stall(result_stall),
        .pair_energy(pair_energy), .pair_force(pair_force),
        .intra_bead(intra_bead), .overflow(overflow)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: check each accepted result, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(pair_energy, pair_force, intra_bead, overflow);
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_chain(logic [30:0] len);
        cfg_valid <= 1;
        cfg_data <= len;
        do @(posedge clk); while (!cfg_ready);
        sb.chain_len = len;
        cfg_valid <= 0;
    endtask

    task automatic send_pair(logic signed [31:0] p1, logic signed [31:0] p2,
                             logic [23:0] d1, logic [23:0] d2,
                             logic [15:0] b1, logic [15:0] b2, bit wrap);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_valid <= 0;
            @(posedge clk);
        end
        pair_valid <= 1;
        first_position <= p1;
        second_position <= p2;
        first_depth <= d1;
        second_depth <= d2;
        first_bead <= b1;
        second_bead <= b2;
        wrap_around <= wrap;
        do @(posedge clk); while (pair_stall);
        sb.note_pair(p1, p2, d1, d2, b1, b2, wrap);
        pairs_sent++;
    endtask

    task automatic drain();
        pair_valid <= 0;
        while (sb.exp_energy.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Mostly separations of a few units around the well, some very close, sometimes anything.
    task automatic random_pair();
        logic signed [31:0] p1;
        logic signed [31:0] offset;
        logic [15:0] b1;
        int kind;
        kind = $urandom_range(9);
        p1 = $urandom;
        if (kind < 6)
            offset = $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
        else if (kind < 8)
            offset = $signed($urandom_range(32'h0000_4000)) - 32'sh0000_2000;
        else
            offset = $urandom;
        b1 = 16'($urandom);
        send_pair(p1, p1 + offset,
                  ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(24'h3_FFFF)),
                  24'($urandom), b1, ($urandom_range(1) == 0) ? b1 : 16'($urandom),
                  1'($urandom_range(1)));
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) random_pair();
    endtask

    initial
    begin
        sb = new();
        pairs_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: zero separation, close, far, zero depth, extremes, wrap.
        send_pair(32'sh0001_0000, 32'sh0001_0000, 24'h01_0000, 24'h01_0000, 0, 0, 0);
        send_pair(0, 32'sh0000_1000, 24'hFF_FFFF, 24'hFF_FFFF, 1, 2, 0);
        send_pair(0, -32'sh0000_1000, 24'hFF_FFFF, 24'hFF_FFFF, 1, 1, 0);
        send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 0, 1);
        send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 24'h01_0000, 24'h01_0000, 16'hFFFF, 16'hFFFF, 0);
        send_pair(0, 32'sh0001_0000, 0, 24'hFF_FFFF, 3, 3, 0);
        send_pair(0, 32'sh0001_0000, 24'hFF_FFFF, 0, 3, 4, 1);
        send_pair(0, 32'sh0001_1F5C, 24'h01_0000, 24'h01_0000, 5, 5, 0);
        send_pair(0, 32'sh0000_5A83, 24'hFF_FFFF, 24'hFF_FFFF, 5, 6, 0);
        send_pair(0, -32'sh0000_5A83, 24'hFF_FFFF, 24'hFF_FFFF, 5, 6, 0);
        send_pair(0, 32'sh0000_5A82, 24'h00_0001, 24'h00_0001, 7, 7, 0);
        send_pair(0, 32'sh0004_0000, 24'h00_0001, 24'h00_0001, 7, 8, 0);
        send_pair(32'shFFFF_FFFF, 0, 24'h80_0000, 24'h80_0000, 9, 9, 0);
        drain();
        write_chain(31'h7FFF_FFFF);
        send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 24'h01_0000, 24'h01_0000, 1, 1, 1);
        send_pair(0, 1, 24'h01_0000, 24'h01_0000, 1, 1, 1);
        drain();
        write_chain(31'h0001_0000);
        send_pair(32'sh0001_0000, 0, 24'h01_0000, 24'h01_0000, 2, 2, 1);
        send_pair(32'sh0000_8000, 0, 24'h01_0000, 24'h01_0000, 2, 2, 1);
        drain();

        send_idle_pct = 21;
        recv_idle_pct = 67;
        write_chain(31'h0003_0000);
        random_phase(450);
        drain();
        send_idle_pct = 67;
        recv_idle_pct = 21;
        write_chain(31'h0);
        random_phase(450);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_chain(31'($urandom_range(32'h0008_0000)));
        random_phase(500);
        drain();

        $display("Ran %0d pairs through five chain length settings, %0d results checked.",
                 pairs_sent, sb.checked);
        $display("Covered zero, close, far and zero-depth pairs with sender and receiver idling.");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
